### src/sirs_pkg.sv
// ----------------------------------------------------------------------------
// sirs_pkg: shared definitions for the radix symbol converter
// widths, register indexes, character limits and the divider status type
// ----------------------------------------------------------------------------
package sirs_pkg;

   localparam int NUMBER_WIDTH      = 32;
   localparam int SYMBOL_WIDTH      = 8;
   localparam int MAX_RADIX         = 16;
   localparam int DIGIT_WIDTH       = $clog2(MAX_RADIX);
   localparam int DIVISOR_WIDTH     = DIGIT_WIDTH + 1;
   localparam int LENGTH_WIDTH      = 5;
   localparam int BIT_COUNT_WIDTH   = $clog2(NUMBER_WIDTH);
   localparam int DIGIT_COUNT_WIDTH = $clog2(NUMBER_WIDTH + 1);
   localparam int STACK_WIDTH       = NUMBER_WIDTH * DIGIT_WIDTH;
   localparam int CSR_DATA_WIDTH    = 64;
   localparam int CSR_INDEX_WIDTH   = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIX_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYMBOLS_LOW  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYMBOLS_HIGH = 2'd2;

   localparam logic [SYMBOL_WIDTH-1:0] CHAR_PLUS   = 8'h2B;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_MINUS  = 8'h2D;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_LOWEST = 8'd33;
   localparam logic [SYMBOL_WIDTH-1:0] CHAR_LIMIT  = 8'd127;

   typedef logic [MAX_RADIX-1:0][SYMBOL_WIDTH-1:0] symbol_table_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      logic [DIGIT_WIDTH-1:0] digit;
      logic                   quotient_zero;
   } div_status_type;

   function automatic logic symbol_illegal(input logic [SYMBOL_WIDTH-1:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c < CHAR_LOWEST) || (c >= CHAR_LIMIT);
   endfunction

endpackage

### src/sirs_if.sv
// ----------------------------------------------------------------------------
// sirs channel interfaces
// valid/ready channels for numbers in and symbols out
// ----------------------------------------------------------------------------
interface sirs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sirs_pkg::NUMBER_WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface sirs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sirs_pkg::SYMBOL_WIDTH-1:0] symbol;
   logic                              last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

### src/sirs_divider.sv
// ----------------------------------------------------------------------------
// sirs_divider: bit-serial restoring divider
// divides a 32-bit magnitude by the radix, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sirs_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [sirs_pkg::NUMBER_WIDTH-1:0]     dividend,
   input  logic [sirs_pkg::DIVISOR_WIDTH-1:0]    divisor,
   output sirs_pkg::div_status_type              status,
   output logic [sirs_pkg::NUMBER_WIDTH-1:0]     quotient
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [sirs_pkg::BIT_COUNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [sirs_pkg::DIGIT_WIDTH-1:0]      rem_ff, rem_in;
   logic [sirs_pkg::NUMBER_WIDTH-1:0]     quo_ff, quo_in;
   logic [sirs_pkg::DIVISOR_WIDTH-1:0]    partial;
   logic [sirs_pkg::DIVISOR_WIDTH-1:0]    diff;
   logic                                  fits;

   always_comb begin
      partial = {rem_ff, quo_ff[sirs_pkg::NUMBER_WIDTH-1]};
      fits    = (partial >= divisor);
      diff    = partial - divisor;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[sirs_pkg::DIGIT_WIDTH-1:0] : partial[sirs_pkg::DIGIT_WIDTH-1:0];
         quo_in = {quo_ff[sirs_pkg::NUMBER_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == sirs_pkg::BIT_COUNT_WIDTH'(sirs_pkg::NUMBER_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy          = busy_ff;
   assign status.done          = done_ff;
   assign status.digit         = rem_ff;
   assign status.quotient_zero = (quo_ff == '0);
   assign quotient             = quo_ff;

endmodule

### src/signed_int_to_radix_symbols_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_symbols_unit: signed integer to radix symbol converter
// writes a signed 32-bit number as symbol bytes from a configured digit table
// ----------------------------------------------------------------------------
// channel   direction  payload               transaction
// req_chan  in         number[31:0] signed   one number
// rsp_chan  out        symbol[7:0], last     one sign or digit symbol
// csr_*     in         index[1:0], data[63:0]  one register write, no handshake
//
// per number: an accept step, a table check step per radix_length entry, a
// bit-serial division per digit, then the sign and digit symbols are emitted
// reset is synchronous and clears control state and the registers
// a stalled rsp_chan holds the output register and pauses emission; a new
// number is taken once the final symbol of the previous one is registered
// ----------------------------------------------------------------------------
module signed_int_to_radix_symbols_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   sirs_req_if.sink                               req_chan,
   sirs_rsp_if.source                             rsp_chan,
   input  logic                                   csr_write_enable,
   input  logic [sirs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [sirs_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_DIVIDE = 3'd2;
   localparam logic [2:0] S_SIGN   = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]                               state_ff, state_in;
   logic [sirs_pkg::LENGTH_WIDTH-1:0]        radix_length_ff, radix_length_in;
   logic [sirs_pkg::CSR_DATA_WIDTH-1:0]      symbols_low_ff, symbols_low_in;
   logic [sirs_pkg::CSR_DATA_WIDTH-1:0]      symbols_high_ff, symbols_high_in;
   sirs_pkg::symbol_table_type               work_ff, work_in;
   logic [sirs_pkg::LENGTH_WIDTH-1:0]        left_ff, left_in;
   logic                                     neg_ff, neg_in;
   logic [sirs_pkg::NUMBER_WIDTH-1:0]        mag_ff, mag_in;
   logic [sirs_pkg::STACK_WIDTH-1:0]         dig_ff, dig_in;
   logic [sirs_pkg::DIGIT_COUNT_WIDTH-1:0]   nd_ff, nd_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [sirs_pkg::SYMBOL_WIDTH-1:0]        rsp_symbol_ff, rsp_symbol_in;
   logic                                     rsp_last_ff, rsp_last_in;

   sirs_pkg::symbol_table_type               sym_tbl;
   sirs_pkg::div_status_type                 div_status;
   logic [sirs_pkg::NUMBER_WIDTH-1:0]        div_quotient;
   logic [sirs_pkg::NUMBER_WIDTH-1:0]        div_dividend;
   logic                                     div_start;
   logic                                     accept;
   logic                                     out_free;
   logic                                     len_bad;
   logic                                     elem_bad;

   assign sym_tbl  = {symbols_high_ff, symbols_low_ff};
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign len_bad  = (radix_length_ff < sirs_pkg::LENGTH_WIDTH'(2)) ||
                     (radix_length_ff > sirs_pkg::LENGTH_WIDTH'(sirs_pkg::MAX_RADIX));

   // symbol at the head of the work copy against its range and the later ones within the remaining length
   always_comb begin
      elem_bad = sirs_pkg::symbol_illegal(work_ff[0]);
      for (int k = 1; k < sirs_pkg::MAX_RADIX; k++) begin
         if ((sirs_pkg::LENGTH_WIDTH'(k) < left_ff) && (work_ff[k] == work_ff[0])) begin
            elem_bad = 1'b1;
         end
      end
   end

   // register writes
   always_comb begin
      radix_length_in = radix_length_ff;
      symbols_low_in  = symbols_low_ff;
      symbols_high_in = symbols_high_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sirs_pkg::CSR_RADIX_LENGTH: radix_length_in = csr_data[sirs_pkg::LENGTH_WIDTH-1:0];
            sirs_pkg::CSR_SYMBOLS_LOW:  symbols_low_in  = csr_data;
            sirs_pkg::CSR_SYMBOLS_HIGH: symbols_high_in = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      left_in       = left_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      dig_in        = dig_ff;
      nd_in         = nd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      div_dividend  = mag_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               neg_in   = req_chan.number[sirs_pkg::NUMBER_WIDTH-1];
               mag_in   = req_chan.number[sirs_pkg::NUMBER_WIDTH-1] ?
                          (sirs_pkg::NUMBER_WIDTH'(0) - req_chan.number) : req_chan.number;
               work_in  = sym_tbl;
               left_in  = radix_length_ff;
               nd_in    = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (len_bad || elem_bad) begin
               state_in = S_IDLE;
            end else if (left_ff == sirs_pkg::LENGTH_WIDTH'(1)) begin
               div_start = 1'b1;
               state_in  = S_DIVIDE;
            end else begin
               work_in = {sirs_pkg::SYMBOL_WIDTH'(0), work_ff[sirs_pkg::MAX_RADIX-1:1]};
               left_in = left_ff - 1'b1;
            end
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               dig_in = {dig_ff[sirs_pkg::STACK_WIDTH-sirs_pkg::DIGIT_WIDTH-1:0],
                         div_status.digit};
               nd_in  = nd_ff + 1'b1;
               if (div_status.quotient_zero) begin
                  state_in = neg_ff ? S_SIGN : S_EMIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_quotient;
               end
            end
         end
         S_SIGN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = sirs_pkg::CHAR_MINUS;
               rsp_last_in   = 1'b0;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = sym_tbl[dig_ff[sirs_pkg::DIGIT_WIDTH-1:0]];
               rsp_last_in   = (nd_ff == sirs_pkg::DIGIT_COUNT_WIDTH'(1));
               dig_in        = dig_ff >> sirs_pkg::DIGIT_WIDTH;
               nd_in         = nd_ff - 1'b1;
               if (nd_ff == sirs_pkg::DIGIT_COUNT_WIDTH'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         radix_length_ff <= '0;
         symbols_low_ff  <= '0;
         symbols_high_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         radix_length_ff <= radix_length_in;
         symbols_low_ff  <= symbols_low_in;
         symbols_high_ff <= symbols_high_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      work_ff       <= work_in;
      left_ff       <= left_in;
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      dig_ff        <= dig_in;
      nd_ff         <= nd_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_last_ff   <= rsp_last_in;
   end

   sirs_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (radix_length_ff[sirs_pkg::DIVISOR_WIDTH-1:0]),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.symbol = rsp_symbol_ff;
   assign rsp_chan.last   = rsp_last_ff;

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT || state_ff == S_SIGN) |-> (nd_ff != '0))
      else $error("emission with empty digit stack");

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_CHECK))
      else $error("accepted number did not enter table check");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == S_DIVIDE))
      else $error("divider finished outside divide state");
`endif

endmodule
